// File: sv/alps_pkg.sv
package alps_pkg;

  localparam int MAX_LIGHTS = 4096;
  localparam int IDX_W      = $clog2(MAX_LIGHTS);
  localparam int CNT_W      = $clog2(MAX_LIGHTS + 1);
  localparam int POWER_W    = 24;
  localparam int PSUM_W     = 36;

  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam logic [32:0] DIST_MAX   = 33'h1_FFFF_FFFF;
  localparam logic [47:0] PDF_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] NEAR_LIMIT = 64'd43;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_FETCH,
    ST_GEOM,
    ST_SQUARE,
    ST_CHECK,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_STORE,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_PDF,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    DV_DIR_X,
    DV_DIR_Y,
    DV_DIR_Z,
    DV_SEL,
    DV_Q
  } div_phase_t;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic [15:0]        blue;
    logic [15:0]        green;
    logic [15:0]        red;
    logic               positive;
    logic [1:0]         axis;
    logic [15:0]        pos_z;
    logic [15:0]        pos_y;
    logic [15:0]        pos_x;
  } entry_t;

endpackage

// File: sv/area_light_power_sampler_core.sv
// Power-weighted sampler over a table of unit-square emitting faces.
// Requests arrive on the s_ channel: tuser carries the operation (clear, append,
// sample, no operation) and tdata the coordinates, face, radiance and random values.
// Each request gives exactly one result on the m_ channel; tuser is the ok flag and
// tdata carries direction, distance, radiance, pdf and the table count.
// Requests are handled one at a time. A sample that runs to the end does a binary
// search over the CDF memory (one read port), a square root, and five long
// divisions on one shared divider. A sample refused at the distance or facing
// test ends sooner. The table and its CDF live in two memories, each with one
// write port and one read port; reads are registered.
// Reset empties the table; there is no clearing pass and the next cycle is ready.
// When the receiver stalls, the result stays in the output register and the block
// holds the next accepted request in its final step until that register is free.
module area_light_power_sampler_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // coord_x, coord_y, coord_z, face_axis, face_positive, emit_red, emit_green,
  // emit_blue, rand_pick, rand_u, rand_v, zero fill
  input  logic [199:0] s_tdata,
  // op
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // dir_x, dir_y, dir_z, light_distance, out_red, out_green, out_blue,
  // sample_density, table_count, zero fill
  output logic [191:0] m_tdata,
  // ok
  output logic [0:0]   m_tuser
);

  localparam int IDX_W = alps_pkg::IDX_W;
  localparam int CNT_W = alps_pkg::CNT_W;

  alps_pkg::state_t     state, state_next;
  alps_pkg::div_phase_t phase;
  alps_pkg::op_t        op;

  logic [CNT_W-1:0] count;
  logic [35:0]      psum;

  alps_pkg::entry_t entry_mem [alps_pkg::MAX_LIGHTS];
  alps_pkg::entry_t entry_rd, entry_wr;
  logic [35:0]      cdf_mem [alps_pkg::MAX_LIGHTS];
  logic [35:0]      cdf_rd;
  logic             mem_we;
  logic [IDX_W-1:0] cdf_raddr, entry_raddr;

  logic        accept;
  logic [32:0] lum;
  logic [23:0] power_new;
  logic        append_ok;

  logic [31:0] pt_x, pt_y, pt_z;
  logic [15:0] rnd_u, rnd_v;
  logic [51:0] target;
  logic [CNT_W-1:0] lo, hi, last;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;

  logic [1:0]  ax;
  logic [16:0] add [3];
  logic [15:0] pos [3];
  logic [31:0] ptk [3];
  logic [34:0] lp [3], off [3];
  logic [33:0] mag [3];
  logic [33:0] mag_or;
  logic [1:0]  s_c;

  logic [30:0] a [3];
  logic [2:0]  neg;
  logic [1:0]  s_r, axis_r;
  logic        positive_r, nz_r;
  logic [15:0] red_r, green_r, blue_r;
  logic [23:0] power_r;

  logic [1:0]  sq_k;
  logic [30:0] a_sel;
  logic [61:0] a_sq;
  logic [63:0] d2;
  logic        near_fail;

  logic [63:0] sq_x, sq_r, sq_b, sq_rb;
  logic [4:0]  sq_cnt;
  logic [31:0] root;

  logic [63:0] div_num;
  logic [35:0] div_den;
  logic [36:0] div_rem, rem_sh;
  logic [6:0]  div_cnt;
  logic [45:0] dir_numer;
  logic [30:0] a_div;

  logic [14:0] dir_r [3];
  logic [14:0] cos_c;
  logic [32:0] sel_r;
  logic [63:0] q_r;
  logic [69:0] q_wide;
  logic [63:0] q_sat;
  logic [64:0] prod_hi, prod_lo;
  logic [48:0] pdf_sum;
  logic [47:0] pdf_c, pdf_r;

  logic        res_ok, res_good;
  logic [34:0] dist_wide;
  logic [32:0] dist_sat;
  logic [15:0] dir_out [3];
  logic        out_load;

  assign op        = alps_pkg::op_t'(s_tuser);
  assign lum       = 33'(s_tdata[114:99])  * 33'(alps_pkg::W_RED)
                   + 33'(s_tdata[130:115]) * 33'(alps_pkg::W_GREEN)
                   + 33'(s_tdata[146:131]) * 33'(alps_pkg::W_BLUE) + 33'd128;
  assign power_new = lum[31:8];
  assign append_ok = (s_tdata[97:96] != 2'd3) && (power_new != 24'd0)
                   && (count < CNT_W'(alps_pkg::MAX_LIGHTS));

  assign entry_wr.power    = power_new;
  assign entry_wr.blue     = s_tdata[146:131];
  assign entry_wr.green    = s_tdata[130:115];
  assign entry_wr.red      = s_tdata[114:99];
  assign entry_wr.positive = s_tdata[98];
  assign entry_wr.axis     = s_tdata[97:96];
  assign entry_wr.pos_z    = s_tdata[95:80];
  assign entry_wr.pos_y    = s_tdata[63:48];
  assign entry_wr.pos_x    = s_tdata[31:16];

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CNT_W:1];
  assign last    = count - CNT_W'(1);

  always_comb begin
    s_tready    = (state == alps_pkg::ST_IDLE);
    accept      = s_tvalid && s_tready;
    mem_we      = accept && (op == alps_pkg::OP_APPEND) && append_ok;
    cdf_raddr   = mid[IDX_W-1:0];
    entry_raddr = (lo < count) ? lo[IDX_W-1:0] : last[IDX_W-1:0];
    out_load    = (state == alps_pkg::ST_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[count[IDX_W-1:0]] <= entry_wr;
      cdf_mem[count[IDX_W-1:0]]   <= psum + 36'(power_new);
    end
    entry_rd <= entry_mem[entry_raddr];
    cdf_rd   <= cdf_mem[cdf_raddr];
  end

  // Point on the face relative to the shading point.
  always_comb begin
    ax     = (entry_rd.axis == 2'd3) ? 2'd2 : entry_rd.axis;
    pos[0] = entry_rd.pos_x;
    pos[1] = entry_rd.pos_y;
    pos[2] = entry_rd.pos_z;
    ptk[0] = pt_x;
    ptk[1] = pt_y;
    ptk[2] = pt_z;
    add[0] = 17'd0;
    add[1] = 17'd0;
    add[2] = 17'd0;
    case (ax)
      2'd0: begin
        add[0] = entry_rd.positive ? 17'h10000 : 17'd0;
        add[1] = 17'(rnd_u);
        add[2] = 17'(rnd_v);
      end
      2'd1: begin
        add[1] = entry_rd.positive ? 17'h10000 : 17'd0;
        add[2] = 17'(rnd_u);
        add[0] = 17'(rnd_v);
      end
      default: begin
        add[2] = entry_rd.positive ? 17'h10000 : 17'd0;
        add[0] = 17'(rnd_u);
        add[1] = 17'(rnd_v);
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      lp[k]  = {{3{pos[k][15]}}, pos[k], 16'd0} + 35'(add[k]);
      off[k] = lp[k] - {{3{ptk[k][31]}}, ptk[k]};
      mag[k] = off[k][34] ? 34'(-off[k]) : off[k][33:0];
    end
    mag_or = mag[0] | mag[1] | mag[2];
    s_c    = mag_or[33] ? 2'd3 : (mag_or[32] ? 2'd2 : (mag_or[31] ? 2'd1 : 2'd0));
  end

  always_comb begin
    case (sq_k)
      2'd0:    a_sel = a[0];
      2'd1:    a_sel = a[1];
      default: a_sel = a[2];
    endcase
    case (phase)
      alps_pkg::DV_DIR_X: a_div = a[0];
      alps_pkg::DV_DIR_Y: a_div = a[1];
      default:            a_div = a[2];
    endcase
    case (axis_r)
      2'd0:    cos_c = dir_r[0];
      2'd1:    cos_c = dir_r[1];
      default: cos_c = dir_r[2];
    endcase
    if (!((neg[axis_r] == positive_r) && nz_r)) cos_c = 15'd0;
  end

  assign a_sq      = a_sel * a_sel;
  assign near_fail = (s_r == 2'd0) && (d2 < alps_pkg::NEAR_LIMIT);
  assign sq_rb     = sq_r + sq_b;
  assign root      = sq_r[31:0];
  assign dir_numer = {a_div, 14'd0} + 46'(root[31:1]);
  assign rem_sh    = {div_rem[35:0], div_num[63]};

  assign q_wide = {6'd0, q_r} << {s_r, 1'b0};
  assign q_sat  = (q_wide[69:64] != 6'd0) ? '1 : q_wide[63:0];

  always_comb begin
    pdf_sum = {1'b0, prod_hi[47:0]} + 49'(prod_lo[64:32]);
    if (prod_hi >= 65'(alps_pkg::PDF_MAX)) begin
      pdf_c = alps_pkg::PDF_MAX;
    end else if (pdf_sum > 49'(alps_pkg::PDF_MAX)) begin
      pdf_c = alps_pkg::PDF_MAX;
    end else begin
      pdf_c = pdf_sum[47:0];
    end
  end

  always_comb begin
    dist_wide = {3'd0, root} << s_r;
    dist_sat  = (dist_wide > 35'(alps_pkg::DIST_MAX)) ? alps_pkg::DIST_MAX
                                                       : dist_wide[32:0];
    for (int k = 0; k < 3; k++) begin
      dir_out[k] = neg[k] ? 16'(-{1'b0, dir_r[k]}) : {1'b0, dir_r[k]};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      alps_pkg::ST_IDLE: begin
        if (accept) begin
          if (op == alps_pkg::OP_SAMPLE && count != '0) state_next = alps_pkg::ST_SEARCH;
          else state_next = alps_pkg::ST_FINISH;
        end
      end
      alps_pkg::ST_SEARCH:  state_next = (lo < hi) ? alps_pkg::ST_COMPARE : alps_pkg::ST_FETCH;
      alps_pkg::ST_COMPARE: state_next = alps_pkg::ST_SEARCH;
      alps_pkg::ST_FETCH:   state_next = alps_pkg::ST_GEOM;
      alps_pkg::ST_GEOM:    state_next = alps_pkg::ST_SQUARE;
      alps_pkg::ST_SQUARE:  if (sq_k == 2'd2) state_next = alps_pkg::ST_CHECK;
      alps_pkg::ST_CHECK:   state_next = near_fail ? alps_pkg::ST_FINISH : alps_pkg::ST_SQRT;
      alps_pkg::ST_SQRT:    if (sq_cnt == 5'd31) state_next = alps_pkg::ST_DIV_LOAD;
      alps_pkg::ST_DIV_LOAD: begin
        if (phase == alps_pkg::DV_SEL && cos_c <= 15'd1) state_next = alps_pkg::ST_FINISH;
        else state_next = alps_pkg::ST_DIV_RUN;
      end
      alps_pkg::ST_DIV_RUN:   if (div_cnt == 7'd1) state_next = alps_pkg::ST_DIV_STORE;
      alps_pkg::ST_DIV_STORE: begin
        state_next = (phase == alps_pkg::DV_Q) ? alps_pkg::ST_MUL_HI : alps_pkg::ST_DIV_LOAD;
      end
      alps_pkg::ST_MUL_HI: state_next = alps_pkg::ST_MUL_LO;
      alps_pkg::ST_MUL_LO: state_next = alps_pkg::ST_PDF;
      alps_pkg::ST_PDF:    state_next = alps_pkg::ST_FINISH;
      alps_pkg::ST_FINISH: if (out_load) state_next = alps_pkg::ST_IDLE;
      default:             state_next = alps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= alps_pkg::ST_IDLE;
      count    <= '0;
      psum     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && op == alps_pkg::OP_CLEAR) begin
        count <= '0;
        psum  <= '0;
      end else if (mem_we) begin
        count <= count + CNT_W'(1);
        psum  <= psum + 36'(power_new);
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      alps_pkg::ST_IDLE: begin
        res_good <= 1'b0;
        res_ok   <= (op == alps_pkg::OP_CLEAR) || (op == alps_pkg::OP_APPEND && append_ok);
        pt_x     <= s_tdata[31:0];
        pt_y     <= s_tdata[63:32];
        pt_z     <= s_tdata[95:64];
        rnd_u    <= s_tdata[178:163];
        rnd_v    <= s_tdata[194:179];
        target   <= 52'(s_tdata[162:147]) * 52'(psum);
        lo       <= '0;
        hi       <= count;
      end
      alps_pkg::ST_COMPARE: begin
        if ({cdf_rd, 16'd0} < target) lo <= mid + CNT_W'(1);
        else hi <= mid;
      end
      alps_pkg::ST_GEOM: begin
        for (int k = 0; k < 3; k++) begin
          a[k]   <= 31'(mag[k] >> s_c);
          neg[k] <= off[k][34];
        end
        s_r        <= s_c;
        axis_r     <= ax;
        positive_r <= entry_rd.positive;
        nz_r       <= (mag[ax] != 34'd0);
        red_r      <= entry_rd.red;
        green_r    <= entry_rd.green;
        blue_r     <= entry_rd.blue;
        power_r    <= entry_rd.power;
        d2         <= '0;
        sq_k       <= 2'd0;
      end
      alps_pkg::ST_SQUARE: begin
        d2   <= d2 + 64'(a_sq);
        sq_k <= sq_k + 2'd1;
      end
      alps_pkg::ST_CHECK: begin
        sq_x   <= d2;
        sq_r   <= '0;
        sq_b   <= 64'h4000_0000_0000_0000;
        sq_cnt <= '0;
        phase  <= alps_pkg::DV_DIR_X;
      end
      alps_pkg::ST_SQRT: begin
        if (sq_x >= sq_rb) begin
          sq_x <= sq_x - sq_rb;
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_b   <= sq_b >> 2;
        sq_cnt <= sq_cnt + 5'd1;
      end
      alps_pkg::ST_DIV_LOAD: begin
        div_rem <= '0;
        case (phase)
          alps_pkg::DV_SEL: begin
            div_num <= {power_r, 40'd0};
            div_den <= psum;
            div_cnt <= 7'd56;
          end
          alps_pkg::DV_Q: begin
            div_num <= d2;
            div_den <= 36'({sel_r[0] & 1'b0, cos_c, 2'b00});
            div_cnt <= 7'd64;
          end
          default: begin
            div_num <= {dir_numer, 18'd0};
            div_den <= 36'(root);
            div_cnt <= 7'd46;
          end
        endcase
      end
      alps_pkg::ST_DIV_RUN: begin
        if (rem_sh >= {1'b0, div_den}) begin
          div_rem <= rem_sh - {1'b0, div_den};
          div_num <= {div_num[62:0], 1'b1};
        end else begin
          div_rem <= rem_sh;
          div_num <= {div_num[62:0], 1'b0};
        end
        div_cnt <= div_cnt - 7'd1;
      end
      alps_pkg::ST_DIV_STORE: begin
        case (phase)
          alps_pkg::DV_DIR_X: begin
            dir_r[0] <= div_num[14:0];
            phase    <= alps_pkg::DV_DIR_Y;
          end
          alps_pkg::DV_DIR_Y: begin
            dir_r[1] <= div_num[14:0];
            phase    <= alps_pkg::DV_DIR_Z;
          end
          alps_pkg::DV_DIR_Z: begin
            dir_r[2] <= div_num[14:0];
            phase    <= alps_pkg::DV_SEL;
          end
          alps_pkg::DV_SEL: begin
            sel_r <= div_num[32:0];
            phase <= alps_pkg::DV_Q;
          end
          default: q_r <= div_num;
        endcase
      end
      alps_pkg::ST_MUL_HI: prod_hi <= 65'(q_sat[63:32]) * 65'(sel_r);
      alps_pkg::ST_MUL_LO: prod_lo <= 65'(q_sat[31:0]) * 65'(sel_r);
      alps_pkg::ST_PDF: begin
        pdf_r    <= pdf_c;
        res_ok   <= (pdf_c != 48'd0);
        res_good <= (pdf_c != 48'd0);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_tuser[0] <= res_ok;
      if (res_good) begin
        m_tdata <= {2'b00, count, pdf_r, blue_r, green_r, red_r, dist_sat,
                    dir_out[2], dir_out[1], dir_out[0]};
      end else begin
        m_tdata <= {2'b00, count, 177'd0};
      end
    end
  end

endmodule

// File: sv/alps_checker.sv
module alps_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata,
  input logic [0:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Request taken while another is in work.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[176:0] == 177'd0)
    else $error("Rejected result carries nonzero fields.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[189:177] <= 13'(alps_pkg::MAX_LIGHTS))
    else $error("Table count out of range.");

endmodule

bind area_light_power_sampler_core alps_checker u_alps_checker (.*);
